@@ rtl/core/tpcs_pkg.sv @@
// shared types and constants for the tree path cursor stack
`timescale 1ns / 1ps

package tpcs_pkg;

    localparam int FUNC_W   = 3;
    localparam int LEVEL_W  = 6;
    localparam int OFFSET_W = 48;
    localparam int ORD_W    = 16;
    localparam int CNT_W    = 16;
    localparam int LENGTH_W = 7;

    localparam int DEF_MAX_LEVELS  = 64;
    localparam int DEF_OFFSET_BITS = 48;

    typedef enum logic [FUNC_W-1:0] {
        FN_RESET = 3'd0,
        FN_PUSH  = 3'd1,
        FN_POP   = 3'd2,
        FN_BUMP  = 3'd3,
        FN_READ  = 3'd4
    } t_func;

endpackage

@@ rtl/core/tree_path_cursor_stack_unit.sv @@
// tree path cursor stack: level store, stack length and one-pass operation logic
//
// input channel (i_valid / o_ready) carries one operation per beat: reset, push,
// pop, bump or read of one level. output channel (o_valid / i_ready) returns one
// result beat per operation: ok, length after the operation, and for a read the
// found flag and the fields of that level.
// an accepted operation waits in the operation register until the result register
// can take it; the result register then drives o_valid and holds the beat until
// i_ready takes it. one operation is taken every cycle while the receiver keeps up; the
// level store is a single-write memory with two registered read ports (addressed
// level and the new top of stack), and a same-cycle write is forwarded to both reads.
// reset leaves one all-zero level and length one; level zero reads as zero until
// it is overwritten, so no clearing pass is run and the block takes beats straight
// after reset.
// when the receiver stalls the result register holds and the operation register
// waits; o_ready drops when both are full and i_ready is low.
`timescale 1ns / 1ps

module tree_path_cursor_stack_unit
    import tpcs_pkg::*;
#(
    parameter int MAX_LEVELS  = DEF_MAX_LEVELS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_valid,
    output logic                o_ready,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [LEVEL_W-1:0]  i_level,
    input  logic [OFFSET_W-1:0] i_new_offset,
    input  logic [ORD_W-1:0]    i_new_ord,
    input  logic [CNT_W-1:0]    i_new_child_count,

    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_ok,
    output logic [LENGTH_W-1:0] o_length,
    output logic                o_found,
    output logic [OFFSET_W-1:0] o_read_offset,
    output logic [ORD_W-1:0]    o_read_ord,
    output logic [CNT_W-1:0]    o_read_child_count
);

    localparam int AW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int LEN_W = $clog2(MAX_LEVELS + 1);
    localparam int CW    = LEN_W + LEVEL_W;

    // level store
    logic [OFFSET_BITS-1:0] mem_off [MAX_LEVELS];
    logic [ORD_W-1:0]       mem_ord [MAX_LEVELS];
    logic [CNT_W-1:0]       mem_cnt [MAX_LEVELS];

    // operation stage
    logic                   r_e_valid;
    t_func                  r_e_func;
    logic [LEVEL_W-1:0]     r_e_level;
    logic [OFFSET_BITS-1:0] r_e_off;
    logic [ORD_W-1:0]       r_e_ord;
    logic [CNT_W-1:0]       r_e_cnt;
    logic [OFFSET_BITS-1:0] r_rd_off;
    logic [ORD_W-1:0]       r_rd_ord;
    logic [CNT_W-1:0]       r_rd_cnt;

    // stack state
    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       n_len;
    logic                   r_z0;
    logic                   n_z0;
    logic [OFFSET_BITS-1:0] r_top_off;

    // result stage
    logic                   r_o_valid;
    logic                   r_o_ok;
    logic [LENGTH_W-1:0]    r_o_len;
    logic                   r_o_found;
    logic [OFFSET_W-1:0]    r_o_off;
    logic [ORD_W-1:0]       r_o_ord;
    logic [CNT_W-1:0]       r_o_cnt;

    logic                   accept;
    logic                   exec;

    logic                   w_en;
    logic [AW-1:0]          w_addr;
    logic [OFFSET_BITS-1:0] w_off;
    logic [ORD_W-1:0]       w_ord;
    logic [CNT_W-1:0]       w_cnt;
    logic                   res_ok;
    logic                   res_found;

    logic [CW-1:0]          lvl_c;
    logic [CW-1:0]          len_c;
    logic [CW-1:0]          max_c;
    logic                   full;
    logic                   off_above;
    logic [ORD_W-1:0]       ord_inc;

    logic [AW-1:0]          rd_addr;
    logic                   rd_fwd;
    logic                   rd_zero;
    logic [AW-1:0]          top_addr;
    logic                   top_fwd;
    logic                   top_zero;

    assign exec    = r_e_valid && (!r_o_valid || i_ready);
    assign o_ready = !r_e_valid || exec;
    assign accept  = i_valid && o_ready;

    assign lvl_c     = CW'(r_e_level);
    assign len_c     = CW'(r_len);
    assign max_c     = CW'(MAX_LEVELS);
    assign full      = (r_len == LEN_W'(MAX_LEVELS));
    assign off_above = (r_e_off > r_top_off);
    assign ord_inc   = (r_rd_ord == '1) ? r_rd_ord : r_rd_ord + 1'b1;

    always_comb begin
        n_len     = r_len;
        n_z0      = r_z0;
        w_en      = 1'b0;
        w_addr    = AW'(r_len);
        w_off     = r_e_off;
        w_ord     = r_e_ord;
        w_cnt     = r_e_cnt;
        res_ok    = 1'b0;
        res_found = 1'b0;
        if (exec) begin
            unique case (r_e_func)
                FN_RESET: begin
                    n_z0   = 1'b1;
                    n_len  = LEN_W'(1);
                    res_ok = 1'b1;
                end
                FN_PUSH: begin
                    if (!full && off_above) begin
                        w_en   = 1'b1;
                        n_len  = r_len + 1'b1;
                        res_ok = 1'b1;
                    end
                end
                FN_POP: begin
                    res_ok = 1'b1;
                    if (r_len == LEN_W'(1)) begin
                        // emptied: back to the single zero level
                        n_z0 = 1'b1;
                    end else begin
                        n_len = r_len - 1'b1;
                    end
                end
                FN_BUMP: begin
                    if (lvl_c >= max_c || lvl_c > len_c) begin
                        res_ok = 1'b0;
                    end else if (lvl_c == len_c) begin
                        if (!full) begin
                            res_ok = 1'b1;
                            w_ord  = '0;
                            if (off_above) begin
                                w_en  = 1'b1;
                                n_len = r_len + 1'b1;
                            end
                        end
                    end else begin
                        w_en   = 1'b1;
                        w_addr = AW'(r_e_level);
                        w_ord  = ord_inc;
                        n_len  = LEN_W'(r_e_level) + 1'b1;
                        res_ok = 1'b1;
                        if (r_e_level == '0) begin
                            n_z0 = 1'b0;
                        end
                    end
                end
                FN_READ: begin
                    if (lvl_c < len_c && lvl_c < max_c) begin
                        res_ok    = 1'b1;
                        res_found = 1'b1;
                    end
                end
                default: begin
                    res_ok = 1'b0;
                end
            endcase
        end
    end

    // read port selects, with the write of this cycle forwarded
    assign rd_addr  = AW'(i_level);
    assign rd_fwd   = w_en && (w_addr == rd_addr);
    assign rd_zero  = n_z0 && (rd_addr == '0);
    assign top_addr = AW'(n_len - 1'b1);
    assign top_fwd  = w_en && (w_addr == top_addr);
    assign top_zero = n_z0 && (top_addr == '0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem_off[w_addr] <= w_off;
            mem_ord[w_addr] <= w_ord;
            mem_cnt[w_addr] <= w_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_e_func  <= t_func'(i_func);
            r_e_level <= i_level;
            r_e_off   <= OFFSET_BITS'(i_new_offset);
            r_e_ord   <= i_new_ord;
            r_e_cnt   <= i_new_child_count;
            if (rd_fwd) begin
                r_rd_off <= w_off;
                r_rd_ord <= w_ord;
                r_rd_cnt <= w_cnt;
            end else if (rd_zero) begin
                r_rd_off <= '0;
                r_rd_ord <= '0;
                r_rd_cnt <= '0;
            end else begin
                r_rd_off <= mem_off[rd_addr];
                r_rd_ord <= mem_ord[rd_addr];
                r_rd_cnt <= mem_cnt[rd_addr];
            end
        end
    end

    // offset of the top level after this cycle's operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_off <= '0;
        end else if (top_fwd) begin
            r_top_off <= w_off;
        end else if (top_zero) begin
            r_top_off <= '0;
        end else begin
            r_top_off <= mem_off[top_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_len     <= LEN_W'(1);
            r_z0      <= 1'b1;
        end else begin
            r_len <= n_len;
            r_z0  <= n_z0;
            if (accept) begin
                r_e_valid <= 1'b1;
            end else if (exec) begin
                r_e_valid <= 1'b0;
            end
            if (exec) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_o_ok    <= res_ok;
            r_o_len   <= LENGTH_W'(n_len);
            r_o_found <= res_found;
            r_o_off   <= res_found ? OFFSET_W'(r_rd_off) : '0;
            r_o_ord   <= res_found ? r_rd_ord : '0;
            r_o_cnt   <= res_found ? r_rd_cnt : '0;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_ok               = r_o_ok;
    assign o_length           = r_o_len;
    assign o_found            = r_o_found;
    assign o_read_offset      = r_o_off;
    assign o_read_ord         = r_o_ord;
    assign o_read_child_count = r_o_cnt;

    // the stack always holds at least one level and never more than the store
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0) && (r_len <= LEN_W'(MAX_LEVELS)))
        else $error("stack length out of range");

    // a refused operation leaves the length alone
    a_refused_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && !res_ok |=> r_len == $past(r_len))
        else $error("refused operation changed the length");

    // a read that finds its level always reports success
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_found |-> r_o_ok)
        else $error("found without ok");

    // pop above the base level drops exactly one level
    a_pop_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && (r_e_func == FN_POP) && (r_len != LEN_W'(1))
        |=> r_len == $past(r_len) - 1'b1)
        else $error("pop did not drop one level");

    // reset operation leaves the single zero level
    a_reset_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && (r_e_func == FN_RESET) |=> r_z0 && (r_len == LEN_W'(1))
        && (r_top_off == '0))
        else $error("reset operation left the wrong state");

endmodule

@@ sim/tree_path_cursor_stack_unit_tb.sv @@
// self-checking testbench for the tree path cursor stack: directed table, then random traffic
`timescale 1ns / 1ps

module tree_path_cursor_stack_unit_tb
    import tpcs_pkg::*;
();

    localparam int MAX_LEVELS   = DEF_MAX_LEVELS;
    localparam int RAND_PER_PHASE = 357;
    localparam int SETTLE_CYCLES  = 8;

    localparam logic [FUNC_W-1:0]   FN_UNDEF_LO = 3'd5;
    localparam logic [FUNC_W-1:0]   FN_UNDEF_MID = 3'd6;
    localparam logic [FUNC_W-1:0]   FN_UNDEF_HI = 3'd7;
    localparam logic [OFFSET_W-1:0] OFF_MAX = {OFFSET_W{1'b1}};
    localparam logic [ORD_W-1:0]    ORD_MAX = {ORD_W{1'b1}};
    localparam logic [CNT_W-1:0]    CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [LEVEL_W-1:0]  level;
        logic [OFFSET_W-1:0] offset;
        logic [ORD_W-1:0]    ord;
        logic [CNT_W-1:0]    cnt;
    } path_op_t;

    typedef struct packed {
        logic                ok;
        logic [LENGTH_W-1:0] length;
        logic                found;
        logic [OFFSET_W-1:0] offset;
        logic [ORD_W-1:0]    ord;
        logic [CNT_W-1:0]    cnt;
    } path_res_t;

    typedef struct {
        path_op_t  op;
        bit        typed;
        path_res_t want;
    } dir_row_t;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [FUNC_W-1:0]   i_func = FN_READ;
    logic [LEVEL_W-1:0]  i_level = '0;
    logic [OFFSET_W-1:0] i_new_offset = '0;
    logic [ORD_W-1:0]    i_new_ord = '0;
    logic [CNT_W-1:0]    i_new_child_count = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic                o_ok;
    logic [LENGTH_W-1:0] o_length;
    logic                o_found;
    logic [OFFSET_W-1:0] o_read_offset;
    logic [ORD_W-1:0]    o_read_ord;
    logic [CNT_W-1:0]    o_read_child_count;

    // predicted stack contents
    logic [OFFSET_W-1:0] lvl_off [MAX_LEVELS];
    logic [ORD_W-1:0]    lvl_ord [MAX_LEVELS];
    logic [CNT_W-1:0]    lvl_cnt [MAX_LEVELS];
    int                  path_depth;

    path_res_t cursor_results_q[$];
    dir_row_t  dir_rows[$];

    int mismatches = 0;
    int ops_sent = 0;
    int results_seen = 0;
    int deepest = 1;
    int full_refusals = 0;
    int climb_left = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    tree_path_cursor_stack_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_func             (i_func),
        .i_level            (i_level),
        .i_new_offset       (i_new_offset),
        .i_new_ord          (i_new_ord),
        .i_new_child_count  (i_new_child_count),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_ok               (o_ok),
        .o_length           (o_length),
        .o_found            (o_found),
        .o_read_offset      (o_read_offset),
        .o_read_ord         (o_read_ord),
        .o_read_child_count (o_read_child_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void clear_root();
        lvl_off[0] = '0;
        lvl_ord[0] = '0;
        lvl_cnt[0] = '0;
        path_depth = 1;
    endfunction

    function automatic bit push_level(logic [OFFSET_W-1:0] off, logic [ORD_W-1:0] ord,
                                      logic [CNT_W-1:0] cnt);
        if (path_depth >= MAX_LEVELS || !(lvl_off[path_depth-1] < off))
            return 1'b0;
        lvl_off[path_depth] = off;
        lvl_ord[path_depth] = ord;
        lvl_cnt[path_depth] = cnt;
        path_depth++;
        return 1'b1;
    endfunction

    function automatic path_res_t step_cursor_stack(path_op_t op);
        path_res_t r;
        int lv;
        r = '0;
        lv = int'(op.level);
        case (op.func)
            FN_RESET: begin
                clear_root();
                r.ok = 1'b1;
            end
            FN_PUSH: r.ok = push_level(op.offset, op.ord, op.cnt);
            FN_POP: begin
                // length never drops below one, so a pop always succeeds
                path_depth--;
                if (path_depth == 0)
                    clear_root();
                r.ok = 1'b1;
            end
            FN_BUMP: begin
                if (lv >= MAX_LEVELS || lv > path_depth) begin
                    r.ok = 1'b0;
                end else if (lv == path_depth) begin
                    // ok even when the push is refused for a low offset
                    void'(push_level(op.offset, '0, op.cnt));
                    r.ok = 1'b1;
                end else begin
                    lvl_off[lv] = op.offset;
                    if (lvl_ord[lv] != ORD_MAX)
                        lvl_ord[lv] = lvl_ord[lv] + 1'b1;
                    lvl_cnt[lv] = op.cnt;
                    path_depth = lv + 1;
                    r.ok = 1'b1;
                end
            end
            FN_READ: begin
                if (lv < path_depth) begin
                    r.ok = 1'b1;
                    r.found = 1'b1;
                    r.offset = lvl_off[lv];
                    r.ord = lvl_ord[lv];
                    r.cnt = lvl_cnt[lv];
                end
            end
            default: ;
        endcase
        r.length = LENGTH_W'(path_depth);
        return r;
    endfunction

    // mostly well-formed traffic shaped by the predicted stack, with bursts that fill it
    function automatic path_op_t pick_path_op();
        path_op_t op;
        logic [OFFSET_W-1:0] top;
        logic [63:0] wide;
        int r;
        top = lvl_off[path_depth-1];
        wide = {$urandom, $urandom};
        op.func = FN_READ;
        op.level = LEVEL_W'($urandom);
        op.offset = wide[OFFSET_W-1:0];
        op.ord = ORD_W'($urandom);
        op.cnt = CNT_W'($urandom);
        r = $urandom_range(0, 99);
        if (climb_left > 0) begin
            climb_left--;
            op.offset = top + 1 + $urandom_range(0, 1000);
            if (r < 25 && path_depth < MAX_LEVELS) begin
                op.func = FN_BUMP;
                op.level = LEVEL_W'(path_depth);
            end else begin
                op.func = FN_PUSH;
            end
        end else if (r < 2) begin
            op.func = FN_RESET;
        end else if (r < 5) begin
            op.func = FUNC_W'($urandom_range(FN_UNDEF_LO, FN_UNDEF_HI));
        end else if (r < 40) begin
            op.func = FN_PUSH;
            if ($urandom_range(0, 99) < 3)
                climb_left = $urandom_range(60, 75);
            case ($urandom_range(0, 5))
                0: ;
                1: op.offset = top - $urandom_range(0, 2);
                default: op.offset = OFFSET_W'(top + 1 + (wide >> $urandom_range(12, 60)));
            endcase
        end else if (r < 52) begin
            op.func = FN_POP;
        end else if (r < 72) begin
            op.func = FN_BUMP;
            case ($urandom_range(0, 4))
                0, 1: op.level = LEVEL_W'((path_depth < MAX_LEVELS) ? path_depth
                                                                   : path_depth - 1);
                2, 3: op.level = LEVEL_W'($urandom_range(0, path_depth - 1));
                default: ;
            endcase
            if ($urandom_range(0, 2) != 0)
                op.offset = top + 1 + $urandom_range(0, 1 << 20);
        end else if ($urandom_range(0, 4) != 0) begin
            op.level = LEVEL_W'($urandom_range(0, path_depth - 1));
        end
        return op;
    endfunction

    task automatic dir_op(logic [FUNC_W-1:0] f, logic [LEVEL_W-1:0] l,
                          logic [OFFSET_W-1:0] off, logic [ORD_W-1:0] ord,
                          logic [CNT_W-1:0] cnt);
        dir_row_t row;
        row.op = '{f, l, off, ord, cnt};
        row.typed = 1'b0;
        row.want = '0;
        dir_rows.push_back(row);
    endtask

    task automatic dir_chk(logic [FUNC_W-1:0] f, logic [LEVEL_W-1:0] l,
                           logic [OFFSET_W-1:0] off, logic [ORD_W-1:0] ord,
                           logic [CNT_W-1:0] cnt, logic ok, logic [LENGTH_W-1:0] len,
                           logic found, logic [OFFSET_W-1:0] r_off,
                           logic [ORD_W-1:0] r_ord, logic [CNT_W-1:0] r_cnt);
        dir_row_t row;
        row.op = '{f, l, off, ord, cnt};
        row.typed = 1'b1;
        row.want = '{ok, len, found, r_off, r_ord, r_cnt};
        dir_rows.push_back(row);
    endtask

    task automatic send_path_op(path_op_t op, bit typed, path_res_t want);
        path_res_t predicted;
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= op.func;
        i_level <= op.level;
        i_new_offset <= op.offset;
        i_new_ord <= op.ord;
        i_new_child_count <= op.cnt;
        do @(posedge i_clk); while (!o_ready);
        if (op.func == FN_PUSH && path_depth == MAX_LEVELS)
            full_refusals++;
        predicted = step_cursor_stack(op);
        if (path_depth > deepest)
            deepest = path_depth;
        cursor_results_q.push_back(typed ? want : predicted);
        ops_sent++;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatches < 100)
            $display("MISMATCH result %0d %s: got %0h want %0h", results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        path_res_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (cursor_results_q.size() == 0) begin
                report_mismatch("beat with nothing pending", 64'(o_length), 64'(0));
            end else begin
                want = cursor_results_q.pop_front();
                if (o_ok !== want.ok)
                    report_mismatch("ok", 64'(o_ok), 64'(want.ok));
                if (o_length !== want.length)
                    report_mismatch("length", 64'(o_length), 64'(want.length));
                if (o_found !== want.found)
                    report_mismatch("found", 64'(o_found), 64'(want.found));
                if (o_read_offset !== want.offset)
                    report_mismatch("read_offset", 64'(o_read_offset), 64'(want.offset));
                if (o_read_ord !== want.ord)
                    report_mismatch("read_ord", 64'(o_read_ord), 64'(want.ord));
                if (o_read_child_count !== want.cnt)
                    report_mismatch("read_child_count", 64'(o_read_child_count),
                                    64'(want.cnt));
            end
            results_seen++;
        end
    end

    initial begin
        int send_pct [4];
        int recv_pct [4];
        send_pct = '{0, 77, 0, 33};
        recv_pct = '{0, 0, 77, 33};
        for (int i = 0; i < MAX_LEVELS; i++) begin
            lvl_off[i] = '0;
            lvl_ord[i] = '0;
            lvl_cnt[i] = '0;
        end
        path_depth = 1;

        dir_chk(FN_READ, 0, 0, 0, 0, 1'b1, 1, 1'b1, 0, 0, 0);
        dir_chk(FN_READ, 1, 0, 0, 0, 1'b0, 1, 1'b0, 0, 0, 0);
        dir_chk(FN_POP, 0, 0, 0, 0, 1'b1, 1, 1'b0, 0, 0, 0);
        // offset equal to the top one is refused
        dir_chk(FN_PUSH, 0, 0, 5, 5, 1'b0, 1, 1'b0, 0, 0, 0);
        dir_chk(FN_PUSH, 0, OFF_MAX, ORD_MAX, CNT_MAX, 1'b1, 2, 1'b0, 0, 0, 0);
        dir_chk(FN_READ, 1, 0, 0, 0, 1'b1, 2, 1'b1, OFF_MAX, ORD_MAX, CNT_MAX);
        dir_chk(FN_PUSH, 0, OFF_MAX, 1, 1, 1'b0, 2, 1'b0, 0, 0, 0);
        // ordinal already at its maximum stays there
        dir_op(FN_BUMP, 1, 5, 0, 0);
        dir_chk(FN_READ, 1, 0, 0, 0, 1'b1, 2, 1'b1, 5, ORD_MAX, 0);
        dir_chk(FN_BUMP, 2, 3, 0, 0, 1'b1, 2, 1'b0, 0, 0, 0);
        dir_op(FN_BUMP, 2, 6, 9, 7);
        dir_op(FN_READ, 2, 0, 0, 0);
        dir_chk(FN_BUMP, 5, 100, 0, 0, 1'b0, 3, 1'b0, 0, 0, 0);
        dir_op(FN_BUMP, 0, 48'h123, 0, 9);
        dir_op(FN_READ, 0, 0, 0, 0);
        dir_chk(FN_UNDEF_LO, 0, 0, 0, 0, 1'b0, 1, 1'b0, 0, 0, 0);
        dir_chk(FN_UNDEF_MID, 63, OFF_MAX, ORD_MAX, CNT_MAX, 1'b0, 1, 1'b0, 0, 0, 0);
        dir_chk(FN_UNDEF_HI, 0, 0, 0, 0, 1'b0, 1, 1'b0, 0, 0, 0);
        // popping the last level brings back the zero root
        dir_op(FN_POP, 0, 0, 0, 0);
        dir_chk(FN_READ, 0, 0, 0, 0, 1'b1, 1, 1'b1, 0, 0, 0);
        dir_op(FN_PUSH, 42, 48'h5555_5555_5555, 16'haaaa, 16'h5555);
        dir_op(FN_PUSH, 21, 48'haaaa_aaaa_aaaa, 16'h5555, 16'haaaa);
        dir_chk(FN_RESET, 0, 0, 0, 0, 1'b1, 1, 1'b0, 0, 0, 0);
        dir_chk(FN_READ, 63, 0, 0, 0, 1'b0, 1, 1'b0, 0, 0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            if (ph == 0) begin
                foreach (dir_rows[k])
                    send_path_op(dir_rows[k].op, dir_rows[k].typed, dir_rows[k].want);
            end
            repeat (RAND_PER_PHASE)
                send_path_op(pick_path_op(), 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (cursor_results_q.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d operations (%0d directed) over four idling phases, %0d results checked",
                 ops_sent, dir_rows.size(), results_seen);
        $display("deepest stack %0d levels, %0d pushes onto a full stack, %0d mismatches",
                 deepest, full_refusals, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
